@@ rtl/krcd_pkg.sv @@
package krcd_pkg;

    localparam int KEY_LIMIT = 7;
    localparam int CNT_W     = 3;

    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_RELEASED = 2'd1;
    localparam logic [1:0] EV_PRESSED  = 2'd2;
    localparam logic [1:0] EV_LINK_ERR = 2'd3;

    typedef logic [7:0] code_t;

    typedef struct packed {
        logic [63:0] response_word;
        logic        response_valid;
    } req_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] key_code;
        logic [1:0] keys_down;
        logic       last_event;
    } evt_t;

    typedef struct packed {
        logic                        link_err;
        logic [KEY_LIMIT-1:0]        rel_mask;
        logic [KEY_LIMIT-1:0]        prs_mask;
        code_t [KEY_LIMIT-1:0]       old_keys;
        code_t [KEY_LIMIT-1:0]       new_keys;
        logic [1:0]                  keys_down;
    } job_t;

    function automatic logic [1:0] sat_count(input logic [CNT_W-1:0] n);
        logic [1:0] r;
        r = (n > CNT_W'(3)) ? 2'd3 : n[1:0];
        return r;
    endfunction

endpackage

@@ rtl/krcd_front.sv @@
module krcd_front #(
    parameter int MAX_KEYS = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  krcd_pkg::req_t    s_data,
    output logic              q_push,
    output krcd_pkg::job_t    q_job,
    input  logic              q_full
);
    import krcd_pkg::*;

    code_t            empty_code_reg;
    code_t            held_reg [MAX_KEYS];
    logic [CNT_W-1:0] held_cnt_reg;

    logic             link_err;
    logic             accept;
    code_t            slot_code [MAX_KEYS];
    logic             nonempty  [MAX_KEYS];
    logic [CNT_W-1:0] pos       [MAX_KEYS+1];
    code_t            new_keys  [MAX_KEYS];
    logic [CNT_W-1:0] new_cnt;
    logic             found;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    always_comb begin
        link_err = !s_data.response_valid || s_data.response_word[63];
        pos[0] = '0;
        for (int i = 0; i < MAX_KEYS; i++) begin
            slot_code[i] = s_data.response_word[8*i+8 +: 8];
            nonempty[i]  = (slot_code[i] != empty_code_reg);
            pos[i+1]     = pos[i] + CNT_W'(nonempty[i]);
        end
        new_cnt = pos[MAX_KEYS];

        // pack non-empty slots in slot order
        for (int j = 0; j < MAX_KEYS; j++) begin
            new_keys[j] = '0;
            for (int i = 0; i < MAX_KEYS; i++) begin
                if (nonempty[i] && pos[i] == CNT_W'(j)) begin
                    new_keys[j] = slot_code[i];
                end
            end
        end

        q_job = '0;
        q_job.link_err = link_err;
        for (int i = 0; i < MAX_KEYS; i++) begin
            q_job.old_keys[i] = held_reg[i];
            q_job.new_keys[i] = new_keys[i];
        end

        for (int i = 0; i < MAX_KEYS; i++) begin
            found = 1'b0;
            for (int j = 0; j < MAX_KEYS; j++) begin
                if (CNT_W'(j) < new_cnt && new_keys[j] == held_reg[i]) begin
                    found = 1'b1;
                end
            end
            q_job.rel_mask[i] = !link_err && (CNT_W'(i) < held_cnt_reg) && !found;
        end

        for (int j = 0; j < MAX_KEYS; j++) begin
            found = 1'b0;
            for (int i = 0; i < MAX_KEYS; i++) begin
                if (CNT_W'(i) < held_cnt_reg && held_reg[i] == new_keys[j]) begin
                    found = 1'b1;
                end
            end
            q_job.prs_mask[j] = !link_err && (CNT_W'(j) < new_cnt) && !found;
        end

        q_job.keys_down = link_err ? sat_count(held_cnt_reg) : sat_count(new_cnt);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            empty_code_reg <= '0;
            held_cnt_reg   <= '0;
            for (int i = 0; i < MAX_KEYS; i++) begin
                held_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                empty_code_reg <= cfg_wr_data;
            end
            if (accept && !link_err) begin
                held_cnt_reg <= new_cnt;
                for (int i = 0; i < MAX_KEYS; i++) begin
                    held_reg[i] <= new_keys[i];
                end
            end
        end
    end

endmodule

@@ rtl/krcd_queue.sv @@
module krcd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  krcd_pkg::job_t    push_job,
    output logic              full,
    output logic              pop_valid,
    input  logic              pop_ready,
    output krcd_pkg::job_t    pop_job
);
    import krcd_pkg::*;

    job_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;

    assign full      = (cnt_reg == 2'd2);
    assign pop_valid = (cnt_reg != 2'd0);
    assign pop_job   = mem[rd_ptr_reg];
    assign pop       = pop_valid && pop_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

@@ rtl/krcd_back.sv @@
module krcd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  krcd_pkg::job_t    q_job,
    output logic              m_valid,
    input  logic              m_ready,
    output krcd_pkg::evt_t    m_data
);
    import krcd_pkg::*;

    job_t                 job_reg;
    job_t                 job_next;
    logic                 job_valid_reg;
    logic                 job_valid_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    evt_t                 m_data_reg;
    evt_t                 m_data_next;

    logic                 advance;
    logic                 fire;
    logic                 done;
    logic                 rel_any;
    logic                 prs_any;
    logic [KEY_LIMIT-1:0] rel_clear;
    logic [KEY_LIMIT-1:0] prs_clear;
    code_t                rel_code;
    code_t                prs_code;
    evt_t                 ev;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        advance   = !m_valid_reg || m_ready;
        rel_any   = |job_reg.rel_mask;
        prs_any   = |job_reg.prs_mask;
        rel_clear = job_reg.rel_mask & (job_reg.rel_mask - KEY_LIMIT'(1));
        prs_clear = job_reg.prs_mask & (job_reg.prs_mask - KEY_LIMIT'(1));

        // lowest pending entry first
        rel_code = '0;
        prs_code = '0;
        for (int i = KEY_LIMIT - 1; i >= 0; i--) begin
            if (job_reg.rel_mask[i]) begin
                rel_code = job_reg.old_keys[i];
            end
            if (job_reg.prs_mask[i]) begin
                prs_code = job_reg.new_keys[i];
            end
        end

        ev.event_kind = EV_NONE;
        ev.key_code   = '0;
        ev.keys_down  = job_reg.keys_down;
        ev.last_event = 1'b1;
        if (job_reg.link_err) begin
            ev.event_kind = EV_LINK_ERR;
        end else if (rel_any) begin
            ev.event_kind = EV_RELEASED;
            ev.key_code   = rel_code;
            ev.last_event = !(|rel_clear) && !prs_any;
        end else if (prs_any) begin
            ev.event_kind = EV_PRESSED;
            ev.key_code   = prs_code;
            ev.last_event = !(|prs_clear);
        end

        fire    = advance && job_valid_reg;
        done    = fire && ev.last_event;
        q_ready = !job_valid_reg || done;

        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        if (fire) begin
            if (rel_any) begin
                job_next.rel_mask = rel_clear;
            end else begin
                job_next.prs_mask = prs_clear;
            end
        end
        if (q_ready) begin
            job_valid_next = q_valid;
            job_next       = q_job;
        end

        m_valid_next = advance ? job_valid_reg : m_valid_reg;
        m_data_next  = fire ? ev : m_data_reg;
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    a_none_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.event_kind == EV_NONE || m_data_reg.event_kind == EV_LINK_ERR))
        |-> (m_data_reg.last_event && m_data_reg.key_code == 8'd0))
        else $error("no-change or link-error event not final or has a code");

    a_job_held_mid_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !ev.last_event) |-> (!q_ready ##1 job_valid_reg))
        else $error("request dropped before its last event");

    a_error_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid_reg && job_reg.link_err) |-> (ev.last_event && !rel_any && !prs_any))
        else $error("link-error request carries key events");

    a_fire_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg)
        else $error("emitted event not presented");

endmodule

@@ rtl/key_rollover_change_detector.sv @@
// Keyboard poll change detector. Each request on s_ is one 64-bit poll response; the block
// packs the non-empty key bytes (slot i at bits 8*i+8 and up, slots equal to the configured
// empty code dropped), compares them with the keys held after the last good poll and emits
// on m_ one event per released key, then one per pressed key, or a single no-change event;
// the final event of a poll has last_event set. A failed poll or a set error bit (bit 63)
// gives one link-error event and keeps the held keys. The front stage classifies one request
// per cycle and writes it into a two-entry queue while that is not full; the back stage
// emits one event per cycle while m_ready is high: one for no change or link error, up to
// 2*MAX_KEYS if every key changes; it takes the next poll as it emits the last event of one.
// Write cfg_wr_en/cfg_wr_data only while no poll is in flight.
module key_rollover_change_detector #(
    parameter int MAX_KEYS = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  krcd_pkg::req_t    s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output krcd_pkg::evt_t    m_data
);
    import krcd_pkg::*;

    logic push;
    logic full;
    logic pop_valid;
    logic pop_ready;
    job_t push_job;
    job_t pop_job;

    krcd_front #(.MAX_KEYS(MAX_KEYS)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_push      (push),
        .q_job       (push_job),
        .q_full      (full)
    );

    krcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (full),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job)
    );

    krcd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (pop_valid),
        .q_ready (pop_ready),
        .q_job   (pop_job),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
